### rtl/sha1bh_pkg.sv
`default_nettype none

package sha1bh_pkg;

  localparam int unsigned NUM_WORDS   = 5;
  localparam int unsigned NUM_ROUNDS  = 80;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_POS     = 56;
  localparam int unsigned LEN_LOW_POS = 60;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

  localparam logic [31:0] K_ROUND [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [31:0] IV_WORD [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef logic [NUM_WORDS-1:0][31:0] word_vec_t;

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_FINISH  = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    CFG_INIT_A = 3'd0,
    CFG_INIT_B = 3'd1,
    CFG_INIT_C = 3'd2,
    CFG_INIT_D = 3'd3,
    CFG_INIT_E = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_e;

  typedef enum logic [1:0] {
    GRP_CHOOSE,
    GRP_PARITY_LO,
    GRP_MAJORITY,
    GRP_PARITY_HI
  } round_grp_e;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_EMIT
  } ret_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_FILL,
    ST_CMP_LOAD,
    ST_CMP_ROUND,
    ST_CMP_ADD,
    ST_EMIT
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       byte_en;
    byte_sel_e  byte_sel;
    logic [1:0] len_idx;
    logic       len_add;
    logic       len_clr;
    logic       chain_init;
    logic       work_load;
    logic       round_en;
    round_grp_e round_grp;
    logic       chain_add;
    logic [2:0] word_sel;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/sha1bh_ifs.sv
`default_nettype none

interface sha1bh_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface sha1bh_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

`default_nettype wire

### rtl/sha1bh_ctrl.sv
`default_nettype none

module sha1bh_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  input  wire logic [1:0]      req_type_i,
  output logic                 req_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [2:0]           word_index_o,
  output logic                 last_o,
  output sha1bh_pkg::cmd_t     cmd_o
);
  import sha1bh_pkg::*;

  state_e     state_q, state_d;
  ret_e       ret_q, ret_d;
  logic [5:0] fill_q, fill_d;
  logic       lenpass_q, lenpass_d;
  logic       done_q, done_d;
  logic [6:0] round_q, round_d;
  logic [2:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= RET_IDLE;
      fill_q    <= '0;
      lenpass_q <= 1'b0;
      done_q    <= 1'b0;
      round_q   <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      fill_q    <= fill_d;
      lenpass_q <= lenpass_d;
      done_q    <= done_d;
      round_q   <= round_d;
      idx_q     <= idx_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fill_d      = fill_q;
    lenpass_d   = lenpass_q;
    done_d      = done_q;
    round_d     = round_q;
    idx_d       = idx_q;
    req_ready_o = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.byte_sel  = BSEL_DATA;
    cmd_o.round_grp = GRP_CHOOSE;
    cmd_o.len_idx   = fill_q[1:0];
    cmd_o.word_sel  = idx_q;

    if (round_q < 7'd20) begin
      cmd_o.round_grp = GRP_CHOOSE;
    end else if (round_q < 7'd40) begin
      cmd_o.round_grp = GRP_PARITY_LO;
    end else if (round_q < 7'd60) begin
      cmd_o.round_grp = GRP_MAJORITY;
    end else begin
      cmd_o.round_grp = GRP_PARITY_HI;
    end

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          case (req_type_i)
            REQ_BYTE: begin
              if (!done_q) begin
                cmd_o.byte_en  = 1'b1;
                cmd_o.byte_sel = BSEL_DATA;
                cmd_o.len_add  = 1'b1;
                fill_d = fill_q + 6'd1;
                if (fill_q == 6'(BLOCK_BYTES - 1)) begin
                  state_d = ST_CMP_LOAD;
                  ret_d   = RET_IDLE;
                end
              end
            end
            REQ_FINISH: begin
              if (done_q) begin
                state_d = ST_EMIT;
              end else begin
                state_d = ST_PAD_MARK;
              end
            end
            REQ_RESTART: begin
              cmd_o.chain_init = 1'b1;
              cmd_o.len_clr    = 1'b1;
              fill_d = '0;
              done_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_PAD_MARK: begin
        cmd_o.byte_en  = 1'b1;
        cmd_o.byte_sel = BSEL_MARK;
        fill_d    = fill_q + 6'd1;
        // length fits in this block only if the marker lands before it
        lenpass_d = (fill_q < 6'(LEN_POS));
        if (fill_q == 6'(BLOCK_BYTES - 1)) begin
          lenpass_d = 1'b1;
          state_d   = ST_CMP_LOAD;
          ret_d     = RET_PAD;
        end else begin
          state_d = ST_PAD_FILL;
        end
      end

      ST_PAD_FILL: begin
        cmd_o.byte_en  = 1'b1;
        cmd_o.byte_sel = (lenpass_q && fill_q >= 6'(LEN_LOW_POS)) ? BSEL_LEN : BSEL_ZERO;
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'(BLOCK_BYTES - 1)) begin
          state_d   = ST_CMP_LOAD;
          ret_d     = lenpass_q ? RET_EMIT : RET_PAD;
          lenpass_d = 1'b1;
        end
      end

      ST_CMP_LOAD: begin
        cmd_o.work_load = 1'b1;
        round_d = '0;
        state_d = ST_CMP_ROUND;
      end

      ST_CMP_ROUND: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 7'd1;
        if (round_q == 7'(NUM_ROUNDS - 1)) begin
          state_d = ST_CMP_ADD;
        end
      end

      ST_CMP_ADD: begin
        cmd_o.chain_add = 1'b1;
        case (ret_q)
          RET_PAD: begin
            state_d = ST_PAD_FILL;
          end
          RET_EMIT: begin
            cmd_o.len_clr = 1'b1;
            done_d  = 1'b1;
            idx_d   = '0;
            state_d = ST_EMIT;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (idx_q == 3'(NUM_WORDS - 1)) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign word_index_o = idx_q;
  assign last_o       = (idx_q == 3'(NUM_WORDS - 1));

endmodule

`default_nettype wire

### rtl/sha1bh_datapath.sv
`default_nettype none

module sha1bh_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sha1bh_pkg::cmd_t     cmd_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire sha1bh_pkg::word_vec_t init_words_i,
  output logic [31:0]               digest_word_o
);
  import sha1bh_pkg::*;

  // 512-bit line: bytes shift in during fill, words shift during rounds;
  // the oldest schedule word sits at the top
  logic [511:0] win_q, win_d;
  logic [31:0]  chain_q [NUM_WORDS];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  bitlen_q;

  logic [7:0]  byte_in;
  logic [31:0] f_val;
  logic [31:0] t_val;
  logic [31:0] w_new;
  logic [31:0] w_cur;
  logic [31:0] sched_x;

  always_comb begin
    case (cmd_i.byte_sel)
      BSEL_DATA: byte_in = data_byte_i;
      BSEL_MARK: byte_in = PAD_MARK_BYTE;
      BSEL_LEN: begin
        case (cmd_i.len_idx)
          2'd0:    byte_in = bitlen_q[31:24];
          2'd1:    byte_in = bitlen_q[23:16];
          2'd2:    byte_in = bitlen_q[15:8];
          default: byte_in = bitlen_q[7:0];
        endcase
      end
      default: byte_in = 8'h00;
    endcase
  end

  assign w_cur   = win_q[511:480];
  assign sched_x = win_q[95:64] ^ win_q[255:224] ^ win_q[447:416] ^ w_cur;
  assign w_new   = {sched_x[30:0], sched_x[31]};

  always_comb begin
    case (cmd_i.round_grp)
      GRP_CHOOSE:   f_val = (b_q & c_q) | (~b_q & d_q);
      GRP_MAJORITY: f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default:      f_val = b_q ^ c_q ^ d_q;
    endcase
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + K_ROUND[cmd_i.round_grp] + w_cur;

  always_comb begin
    win_d = win_q;
    if (cmd_i.byte_en) begin
      win_d = {win_q[503:0], byte_in};
    end else if (cmd_i.round_en) begin
      win_d = {win_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (cmd_i.work_load) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (cmd_i.round_en) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain_q[i] <= IV_WORD[i];
      end
      bitlen_q <= '0;
    end else begin
      if (cmd_i.chain_init) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          chain_q[i] <= init_words_i[i];
        end
      end else if (cmd_i.chain_add) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end
      if (cmd_i.len_clr) begin
        bitlen_q <= '0;
      end else if (cmd_i.len_add) begin
        bitlen_q <= bitlen_q + 32'd8;
      end
    end
  end

  always_comb begin
    case (cmd_i.word_sel)
      3'd0:    digest_word_o = chain_q[0];
      3'd1:    digest_word_o = chain_q[1];
      3'd2:    digest_word_o = chain_q[2];
      3'd3:    digest_word_o = chain_q[3];
      default: digest_word_o = chain_q[4];
    endcase
  end

endmodule

`default_nettype wire

### rtl/sha1_byte_stream_hasher.sv
`default_nettype none

// SHA-1 hasher fed one message byte per beat on req_i. A byte beat (type 0)
// that completes a 64-byte block also starts the compression, which holds
// req_i.ready low through a load step, 80 rounds at one round per cycle
// through a single round unit and an add step, so no new byte is taken
// until the block is compressed. A finish beat (type 1) pads the message
// one byte per cycle up to the block end, into a further block when the
// length field does not fit there, runs one or two compressions and then
// shows the five digest words on dig_o, word A first, with last set on the
// fifth beat. A second finish re-sends the stored digest right away; bytes
// after a finish are dropped until a restart beat (type 2) reloads the
// chaining words from the five init registers. The message length is
// counted modulo 2^32 bits. The init registers sit on the APB port at byte
// addresses 0, 4, 8, 12 and 16, reset to the standard SHA-1 initial values
// and take effect at the next restart; write them only while the block is
// idle.

module sha1_byte_stream_hasher (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sha1bh_req_if.sink   req_i,
  sha1bh_dig_if.source dig_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import sha1bh_pkg::*;

  word_vec_t init_q;
  cmd_t      cmd;
  logic      cfg_wr;
  logic [2:0] cfg_idx;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        init_q[i] <= IV_WORD[i];
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_INIT_A: init_q[0] <= pwdata;
        CFG_INIT_B: init_q[1] <= pwdata;
        CFG_INIT_C: init_q[2] <= pwdata;
        CFG_INIT_D: init_q[3] <= pwdata;
        CFG_INIT_E: init_q[4] <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_INIT_A: prdata = init_q[0];
      CFG_INIT_B: prdata = init_q[1];
      CFG_INIT_C: prdata = init_q[2];
      CFG_INIT_D: prdata = init_q[3];
      CFG_INIT_E: prdata = init_q[4];
      default:    prdata = '0;
    endcase
  end

  // sequencing: byte intake, padding, round count and digest beats
  sha1bh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_type_i   (req_i.req_type),
    .req_ready_o  (req_i.ready),
    .out_valid_o  (dig_o.valid),
    .out_ready_i  (dig_o.ready),
    .word_index_o (dig_o.word_index),
    .last_o       (dig_o.last),
    .cmd_o        (cmd)
  );

  // block line, round unit, chaining words and length counter
  sha1bh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (req_i.data_byte),
    .init_words_i  (init_q),
    .digest_word_o (dig_o.digest_word)
  );

endmodule

`default_nettype wire
